@@ hdl/three_sensor_calibrate_and_steer_unit_defines.svh @@
// Shared assertion macros for the light-steering unit.
// Each expects signals named clock and reset in the scope of use.
`ifndef THREE_SENSOR_CALIBRATE_AND_STEER_UNIT_DEFINES_SVH
`define THREE_SENSOR_CALIBRATE_AND_STEER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TSCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TSCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tscs_pkg.sv @@
package tscs_pkg;

   // Sample width of each converter channel
   localparam int SAMPLE_BITS = 10;
   // Threshold is signed and one bit wider than a sample
   localparam int THR_BITS    = SAMPLE_BITS + 1;
   localparam int COUNT_BITS  = 16;
   localparam int OFFSET_BITS = 8;
   localparam int MARGIN_BITS = 8;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [COUNT_BITS-1:0]  CAL_SAMPLES_RESET = COUNT_BITS'(50000);
   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET      = OFFSET_BITS'(30);
   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET      = MARGIN_BITS'(50);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [THR_BITS-1:0] thr_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CAL_SAMPLES = 2'd0,
      CSR_THR_OFFSET  = 2'd1,
      CSR_MARGIN      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_STOP     = 2'd0,
      DIR_STRAIGHT = 2'd1,
      DIR_LEFT     = 2'd2,
      DIR_RIGHT    = 2'd3
   } dir_type;

   // Bridge bits b3..b0
   localparam logic [3:0] PAT_STOP     = 4'd0;
   localparam logic [3:0] PAT_STRAIGHT = 4'd10;
   localparam logic [3:0] PAT_LEFT     = 4'd9;
   localparam logic [3:0] PAT_RIGHT    = 4'd6;

   // Control from the phase controller to the lanes and the merge stage
   typedef struct packed {
      logic                   calibrating;
      logic                   update;
      thr_type                threshold;
      logic [MARGIN_BITS-1:0] margin;
   } ctrl_type;

   function automatic logic [3:0] pattern_of(dir_type dir);
      logic [3:0] pat;
      case (dir)
         DIR_STRAIGHT: pat = PAT_STRAIGHT;
         DIR_LEFT:     pat = PAT_LEFT;
         DIR_RIGHT:    pat = PAT_RIGHT;
         default:      pat = PAT_STOP;
      endcase
      return pat;
   endfunction

endpackage

@@ hdl/tscs_req_if.sv @@
interface tscs_req_if;
   import tscs_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_left;
   sample_type sample_center;
   sample_type sample_right;

   modport source (output valid, output sample_left, output sample_center,
                   output sample_right, input ready);
   modport sink   (input valid, input sample_left, input sample_center,
                   input sample_right, output ready);
endinterface

@@ hdl/tscs_rsp_if.sv @@
interface tscs_rsp_if;
   import tscs_pkg::*;

   logic       valid;
   logic       ready;
   logic       calibrating;
   logic [1:0] direction;
   logic [3:0] motor_pattern;
   thr_type    threshold_level;

   modport source (output valid, output calibrating, output direction,
                   output motor_pattern, output threshold_level, input ready);
   modport sink   (input valid, input calibrating, input direction,
                   input motor_pattern, input threshold_level, output ready);
endinterface

@@ hdl/tscs_lane.sv @@
// One sensor channel: running minimum plus win test against the other two
module tscs_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  tscs_pkg::ctrl_type    ctl,
   input  tscs_pkg::sample_type  sample_own,
   input  tscs_pkg::sample_type  sample_a,
   input  tscs_pkg::sample_type  sample_b,
   output tscs_pkg::sample_type  min_next,
   output logic                  win
);
   import tscs_pkg::*;

   sample_type               min_ff;
   logic [SAMPLE_BITS:0]     own_plus_margin;
   logic                     below_thr;

   // Minimum after this word
   assign min_next = (ctl.update && (sample_own < min_ff)) ? sample_own : min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '1;
      end else begin
         min_ff <= min_next;
      end
   end

   // own < other - margin  <=>  own + margin < other
   assign own_plus_margin = {1'b0, sample_own} + (SAMPLE_BITS+1)'(ctl.margin);
   assign below_thr       = $signed({1'b0, sample_own}) < ctl.threshold;

   assign win = below_thr
             && (own_plus_margin < {1'b0, sample_a})
             && (own_plus_margin < {1'b0, sample_b});

endmodule

@@ hdl/tscs_ctrl.sv @@
// Phase control: config registers, calibration count, threshold
module tscs_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [tscs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tscs_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   input  logic                                   accept,
   input  tscs_pkg::sample_type                   min_left,
   input  tscs_pkg::sample_type                   min_center,
   input  tscs_pkg::sample_type                   min_right,
   output tscs_pkg::ctrl_type                     ctl
);
   import tscs_pkg::*;

   `include "three_sensor_calibrate_and_steer_unit_defines.svh"

   logic [COUNT_BITS-1:0]  cal_samples_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [MARGIN_BITS-1:0] margin_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   thr_type                thr_ff;
   logic                   running_ff;

   logic                   cal_item;
   logic                   form;
   sample_type             least;
   thr_type                new_thr;

   // Config writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_samples_ff <= CAL_SAMPLES_RESET;
         offset_ff      <= OFFSET_RESET;
         margin_ff      <= MARGIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAL_SAMPLES: cal_samples_ff <= csr_write_data[COUNT_BITS-1:0];
            CSR_THR_OFFSET:  offset_ff      <= csr_write_data[OFFSET_BITS-1:0];
            CSR_MARGIN:      margin_ff      <= csr_write_data[MARGIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Phase decision for the word at the input
   always_comb begin
      cal_item = !running_ff && (count_ff < cal_samples_ff);
      count_in = count_ff + COUNT_BITS'(1);
      form     = !running_ff && (!cal_item || (count_in >= cal_samples_ff));
      least    = min_left;
      if (min_center < least) least = min_center;
      if (min_right < least) least = min_right;
      new_thr  = $signed({1'b0, least}) - $signed({{(THR_BITS-OFFSET_BITS){1'b0}}, offset_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         thr_ff     <= '0;
         running_ff <= 1'b0;
      end else if (accept) begin
         if (cal_item) count_ff <= count_in;
         if (form) begin
            thr_ff     <= new_thr;
            running_ff <= 1'b1;
         end
      end
   end

   assign ctl.calibrating = cal_item;
   assign ctl.update      = accept && cal_item;
   assign ctl.threshold   = form ? new_thr : thr_ff;
   assign ctl.margin      = margin_ff;

   `TSCS_ASSERT_NEXT(a_run_sticky, running_ff, running_ff, "run phase left without reset")
   `TSCS_ASSERT_NEXT(a_thr_frozen, running_ff, $stable(thr_ff), "threshold moved in run phase")
   `TSCS_ASSERT_NEXT(a_form_enters_run, accept && form, running_ff && (thr_ff == $past(new_thr)),
      "threshold formed but run phase not entered")

endmodule

@@ hdl/tscs_merge.sv @@
// Priority merge of the lane wins and the result output register
module tscs_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  tscs_pkg::ctrl_type  ctl,
   input  logic                win_left,
   input  logic                win_center,
   input  logic                win_right,
   output logic                load_ok,
   tscs_rsp_if.source          rsp
);
   import tscs_pkg::*;

   `include "three_sensor_calibrate_and_steer_unit_defines.svh"

   logic       valid_ff;
   logic       cal_ff;
   dir_type    dir_ff;
   dir_type    dir_in;
   thr_type    thr_ff;

   // Center first, then channel 0, then channel 2
   always_comb begin
      if (ctl.calibrating) dir_in = DIR_STOP;
      else if (win_center) dir_in = DIR_STRAIGHT;
      else if (win_left)   dir_in = DIR_LEFT;
      else if (win_right)  dir_in = DIR_RIGHT;
      else                 dir_in = DIR_STOP;
   end

   // Output register takes a new word whenever the old one leaves
   assign load_ok = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cal_ff <= ctl.calibrating;
         dir_ff <= dir_in;
         thr_ff <= ctl.threshold;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.calibrating     = cal_ff;
   assign rsp.direction       = dir_ff;
   assign rsp.motor_pattern   = pattern_of(dir_ff);
   assign rsp.threshold_level = thr_ff;

   `TSCS_ASSERT_NEXT(a_cal_stops, accept && ctl.calibrating, dir_ff == DIR_STOP,
      "calibration word steered")
   `TSCS_ASSERT_NOW(a_accept_room, accept, load_ok, "word loaded over a pending result")

endmodule

@@ hdl/three_sensor_calibrate_and_steer_unit.sv @@
// Latency: a result word is valid the cycle after its input word is accepted.
// Throughput: one word per cycle; the output register refills while it drains,
// so only a stalled result holds off the input.
// Reset (synchronous, active high): minima to all ones, count and threshold to
// zero, calibration phase, config registers to 50000 / 30 / 50; no clear pass.
module three_sensor_calibrate_and_steer_unit (
   input  logic                                clock,
   input  logic                                reset,
   tscs_req_if.sink                            req_channel,
   tscs_rsp_if.source                          rsp_channel,
   input  logic                                csr_write_enable,
   input  logic [tscs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tscs_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import tscs_pkg::*;

   ctrl_type   ctl;
   logic       accept;
   logic       load_ok;
   sample_type min_left;
   sample_type min_center;
   sample_type min_right;
   logic       win_left;
   logic       win_center;
   logic       win_right;

   assign req_channel.ready = load_ok;
   assign accept            = req_channel.valid && load_ok;

   tscs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .min_left         (min_left),
      .min_center       (min_center),
      .min_right        (min_right),
      .ctl              (ctl)
   );

   // Three lanes, one per sensor
   tscs_lane u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample_own (req_channel.sample_left),
      .sample_a   (req_channel.sample_center),
      .sample_b   (req_channel.sample_right),
      .min_next   (min_left),
      .win        (win_left)
   );

   tscs_lane u_lane_center (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample_own (req_channel.sample_center),
      .sample_a   (req_channel.sample_left),
      .sample_b   (req_channel.sample_right),
      .min_next   (min_center),
      .win        (win_center)
   );

   tscs_lane u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample_own (req_channel.sample_right),
      .sample_a   (req_channel.sample_left),
      .sample_b   (req_channel.sample_center),
      .min_next   (min_right),
      .win        (win_right)
   );

   tscs_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .ctl        (ctl),
      .win_left   (win_left),
      .win_center (win_center),
      .win_right  (win_right),
      .load_ok    (load_ok),
      .rsp        (rsp_channel)
   );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import tscs_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SEGMENTS     = 6;
   localparam int SEGMENT_WORDS = 323;

   typedef struct packed {
      logic       calibrating;
      dir_type    direction;
      logic [3:0] motor_pattern;
      thr_type    threshold_level;
   } steer_word_type;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      sample_type                left;
      sample_type                center;
      sample_type                right;
      bit                        typed;
      steer_word_type            result;
   } plan_row_type;

   // Any word consumed by calibration before the threshold exists
   localparam steer_word_type CAL_IDLE = '{1'b1, DIR_STOP, PAT_STOP, thr_type'(0)};

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   tscs_req_if req_if ();
   tscs_rsp_if rsp_if ();

   three_sensor_calibrate_and_steer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: config copy, per-channel minima, phase
   logic [COUNT_BITS-1:0]  cfg_cal_samples;
   logic [OFFSET_BITS-1:0] cfg_offset;
   logic [MARGIN_BITS-1:0] cfg_margin;
   sample_type             seen_min_left;
   sample_type             seen_min_center;
   sample_type             seen_min_right;
   logic [COUNT_BITS-1:0]  cal_count;
   thr_type                steer_threshold;
   bit                     steering;

   steer_word_type pending_steer_q[$];
   int             mismatch_count;
   int             send_gap_pct;
   int             recv_stall_pct;
   int             cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Channel wins: below threshold and more than margin below both others
   function automatic bit channel_leads(int me, int a, int b);
      return me < int'(steer_threshold) && me < a - int'(cfg_margin)
         && me < b - int'(cfg_margin);
   endfunction

   // Expected result of one sample word; advances the predictor state
   function automatic steer_word_type predict_steer(sample_type l, sample_type c,
                                                    sample_type r);
      steer_word_type w;
      sample_type     least;
      w = '{1'b0, DIR_STOP, PAT_STOP, thr_type'(0)};
      if (!steering) begin
         if (cal_count < cfg_cal_samples) begin
            if (l < seen_min_left) seen_min_left = l;
            if (c < seen_min_center) seen_min_center = c;
            if (r < seen_min_right) seen_min_right = r;
            cal_count = cal_count + COUNT_BITS'(1);
            w.calibrating = 1'b1;
         end
         // covers both the last calibration word and a count already reached
         if (cal_count >= cfg_cal_samples) begin
            least = seen_min_left;
            if (seen_min_center < least) least = seen_min_center;
            if (seen_min_right < least) least = seen_min_right;
            steer_threshold = thr_type'(int'(least) - int'(cfg_offset));
            steering = 1'b1;
         end
      end
      if (!w.calibrating) begin
         if (channel_leads(int'(c), int'(l), int'(r))) begin
            w.direction = DIR_STRAIGHT;
            w.motor_pattern = PAT_STRAIGHT;
         end else if (channel_leads(int'(l), int'(c), int'(r))) begin
            w.direction = DIR_LEFT;
            w.motor_pattern = PAT_LEFT;
         end else if (channel_leads(int'(r), int'(l), int'(c))) begin
            w.direction = DIR_RIGHT;
            w.motor_pattern = PAT_RIGHT;
         end
      end
      w.threshold_level = steer_threshold;
      return w;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_INDEX_BITS-1:0] idx,
                                            logic [CSR_DATA_BITS-1:0] data);
      plan_row_type row;
      row.kind   = ROW_CSR;
      row.index  = idx;
      row.data   = data;
      row.left   = '0;
      row.center = '0;
      row.right  = '0;
      row.typed  = 1'b0;
      row.result = CAL_IDLE;
      return row;
   endfunction

   function automatic plan_row_type word_row(sample_type l, sample_type c, sample_type r);
      plan_row_type row;
      row = csr_row(CSR_CAL_SAMPLES, '0);
      row.kind   = ROW_WORD;
      row.left   = l;
      row.center = c;
      row.right  = r;
      return row;
   endfunction

   // Calibration word whose result is known without the predictor
   function automatic plan_row_type cal_row(sample_type l, sample_type c, sample_type r);
      plan_row_type row;
      row = word_row(l, c, r);
      row.typed = 1'b1;
      return row;
   endfunction

   // Random sample set: mostly one channel near the threshold with the
   // others near the margin boundary, the rest uniform with extremes
   function automatic plan_row_type random_row();
      int v[3];
      int w;
      if ($urandom_range(0, 9) < 6) begin
         w = $urandom_range(0, 2);
         v[w] = int'(steer_threshold) - int'($urandom_range(0, 48))
            + int'($urandom_range(0, 1));
         for (int k = 0; k < 3; k++) begin
            if (k != w) begin
               if ($urandom_range(0, 3) == 0) v[k] = $urandom_range(0, SAMPLE_MAX);
               else v[k] = v[w] + int'(cfg_margin) + int'($urandom_range(0, 3)) - 1;
            end
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
               0:       v[k] = 0;
               1:       v[k] = SAMPLE_MAX;
               default: v[k] = $urandom_range(0, SAMPLE_MAX);
            endcase
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (v[k] < 0) v[k] = 0;
         else if (v[k] > SAMPLE_MAX) v[k] = SAMPLE_MAX;
      end
      return word_row(sample_type'(v[0]), sample_type'(v[1]), sample_type'(v[2]));
   endfunction

   // Register write, only once every result is back
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      req_if.valid <= 1'b0;
      while (pending_steer_q.size() != 0) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_CAL_SAMPLES: cfg_cal_samples = data;
         CSR_THR_OFFSET:  cfg_offset = data[OFFSET_BITS-1:0];
         CSR_MARGIN:      cfg_margin = data[MARGIN_BITS-1:0];
         default:         ;
      endcase
      @(negedge clock);
   endtask

   // Drive one sample word; valid stays up until the task after decides
   task automatic send_word(input plan_row_type row);
      steer_word_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.sample_left   <= row.left;
      req_if.sample_center <= row.center;
      req_if.sample_right  <= row.right;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = predict_steer(row.left, row.center, row.right);
      pending_steer_q.push_back(row.typed ? row.result : predicted);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [15:0] want,
                              input logic signed [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result side backpressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Result checker
   always @(posedge clock) begin
      steer_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_steer_q.size() == 0) begin
            $error("result word with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_steer_q.pop_front();
            check_field("calibrating", 16'(want.calibrating), 16'(rsp_if.calibrating));
            check_field("direction", 16'(want.direction), 16'(rsp_if.direction));
            check_field("motor_pattern", 16'(want.motor_pattern),
                        16'(rsp_if.motor_pattern));
            check_field("threshold_level", 16'(want.threshold_level),
                        16'(rsp_if.threshold_level));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      plan_row_type plan[$];
      logic [MARGIN_BITS-1:0] margin_pick;

      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_CAL_SAMPLES;
      csr_write_data       = '0;
      req_if.valid         = 1'b0;
      req_if.sample_left   = '0;
      req_if.sample_center = '0;
      req_if.sample_right  = '0;
      rsp_if.ready         = 1'b0;
      mismatch_count       = 0;
      cycle_count          = 0;
      send_gap_pct         = 30;
      recv_stall_pct       = 75;

      cfg_cal_samples = CAL_SAMPLES_RESET;
      cfg_offset      = OFFSET_RESET;
      cfg_margin      = MARGIN_RESET;
      seen_min_left   = sample_type'(SAMPLE_MAX);
      seen_min_center = sample_type'(SAMPLE_MAX);
      seen_min_right  = sample_type'(SAMPLE_MAX);
      cal_count       = '0;
      steer_threshold = '0;
      steering        = 1'b0;

      // Calibration with extreme settings, then lower the count below what
      // was already seen so the next word forms the threshold and is steered
      plan.push_back(csr_row(CSR_CAL_SAMPLES, 16'd65535));
      plan.push_back(csr_row(CSR_THR_OFFSET, 16'd0));
      plan.push_back(csr_row(CSR_MARGIN, 16'd255));
      plan.push_back(cal_row(10'd1023, 10'd1023, 10'd1023));
      plan.push_back(cal_row(10'd1023, 10'd900, 10'd1000));
      plan.push_back(cal_row(10'd800, 10'd1023, 10'd700));
      plan.push_back(csr_row(CSR_SPARE_INDEX, 16'hFFFF));
      plan.push_back(csr_row(CSR_THR_OFFSET, 16'd255));
      plan.push_back(csr_row(CSR_CAL_SAMPLES, 16'd2));
      plan.push_back(word_row(10'd850, 10'd750, 10'd950));
      // Running: offset and count writes must not matter any more
      plan.push_back(csr_row(CSR_MARGIN, 16'd0));
      plan.push_back(csr_row(CSR_THR_OFFSET, 16'd0));
      plan.push_back(csr_row(CSR_CAL_SAMPLES, 16'd1));
      plan.push_back(word_row(10'd1023, 10'd0, 10'd1023));
      plan.push_back(word_row(10'd0, 10'd1023, 10'd1023));
      plan.push_back(word_row(10'd1023, 10'd1023, 10'd0));
      plan.push_back(word_row(10'd0, 10'd0, 10'd0));
      plan.push_back(word_row(10'd444, 10'd445, 10'd1023));
      plan.push_back(word_row(10'd445, 10'd1023, 10'd1023));
      plan.push_back(word_row(10'd100, 10'd101, 10'd100));
      plan.push_back(csr_row(CSR_MARGIN, 16'd255));
      plan.push_back(word_row(10'd189, 10'd1023, 10'd444));
      plan.push_back(word_row(10'd188, 10'd1023, 10'd444));

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_csr(plan[i].index, plan[i].data);
         else send_word(plan[i]);
      end

      // Random segments, each with its own margin; segments share an idle pattern in pairs
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin
               send_gap_pct   = 30;
               recv_stall_pct = 75;
            end
            1: begin
               send_gap_pct   = 75;
               recv_stall_pct = 30;
            end
            default: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
         endcase
         case (seg)
            0:       margin_pick = 8'd0;
            1:       margin_pick = 8'd255;
            3:       margin_pick = 8'd1;
            default: margin_pick = MARGIN_BITS'($urandom_range(0, 255));
         endcase
         write_csr(CSR_MARGIN, CSR_DATA_BITS'(margin_pick));
         write_csr(CSR_THR_OFFSET, CSR_DATA_BITS'($urandom_range(0, 255)));
         write_csr(CSR_CAL_SAMPLES, CSR_DATA_BITS'($urandom_range(1, 65535)));
         for (int n = 0; n < SEGMENT_WORDS; n++) send_word(random_row());
      end

      req_if.valid <= 1'b0;
      while (pending_steer_q.size() != 0) @(negedge clock);
      // catch any stray result word
      repeat (4) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
